// ===== rtl/lfps_pkg.sv =====
`default_nettype none

package lfps_pkg;

   localparam int unsigned TICKS_PER_MS_DEFAULT = 1000;

   localparam logic [7:0] FULL_LEVEL = 8'd255;

   // Command codes carried in req_tuser.
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_FULL  = 2'd2;
   localparam logic [1:0] CMD_LEVEL = 2'd3;

   // Register indexes, taken from csr_paddr[4:2].
   localparam logic [2:0] REG_ON_MS          = 3'd0;
   localparam logic [2:0] REG_OFF_MS         = 3'd1;
   localparam logic [2:0] REG_PAUSE_MS       = 3'd2;
   localparam logic [2:0] REG_START_DELAY_MS = 3'd3;
   localparam logic [2:0] REG_PULSES         = 3'd4;
   localparam logic [2:0] REG_REPEATS        = 3'd5;
   localparam logic [2:0] REG_RAMP_STEP_US   = 3'd6;
   localparam logic [2:0] REG_DIM_LEVEL      = 3'd7;

   localparam int unsigned CSR_ADDR_W = 5;

endpackage

`default_nettype wire

// ===== rtl/led_flash_pattern_sequencer_core.sv =====
`default_nettype none

// Channel  Direction  Handshake               Payload
// req      in         req_tvalid/req_tready   tuser: command, tdata: level
// rsp      out        rsp_tvalid/rsp_tready   tdata: brightness, done_res, on_phase
// csr      in         APB psel/penable        8 registers at byte address 4*i
//
// Each command updates the sequencer state and loads the result register at the same
// edge, so a beat can be accepted in every cycle while the result register is empty or
// its result is being taken; the result register frees as soon as its beat is taken.
// A stalled result holds req_tready low until rsp_tready rises.
// Synchronous reset clears the registers, the state and the result valid flag.

module led_flash_pattern_sequencer_core #(
   parameter int unsigned TICKS_PER_MS = lfps_pkg::TICKS_PER_MS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Input beats
   input  wire logic                             req_tvalid,
   output      logic                             req_tready,
   input  wire logic [7:0]                       req_tdata,   // [7:0] level
   input  wire logic [1:0]                       req_tuser,   // [1:0] command
   // Result beats
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   output      logic [15:0]                      rsp_tdata,   // [7:0] brightness,
                                                              // [8] done_res,
                                                              // [9] on_phase, rest zero
   // Configuration
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [lfps_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [31:0]                      csr_pwdata,
   output      logic [31:0]                      csr_prdata,
   output      logic                             csr_pready
);

   import lfps_pkg::*;

   localparam int unsigned SUB_W = (TICKS_PER_MS > 1) ? $clog2(TICKS_PER_MS) : 1;
   localparam logic [SUB_W:0] TICKS_C = (SUB_W + 1)'(TICKS_PER_MS);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_DELAY,
      PH_PULSE_ON,
      PH_ON,
      PH_PULSE_OFF,
      PH_OFF,
      PH_BURST,
      PH_PAUSE
   } phase_type;

   // Configuration registers
   logic [15:0] on_ms_ff, off_ms_ff, pause_ms_ff, start_delay_ms_ff;
   logic [7:0]  pulses_ff, repeats_ff, ramp_step_ff, dim_level_ff;

   // Sequencer state
   phase_type        phase_ff, phase_in;
   logic [7:0]       pulse_count_ff, pulse_count_in;
   logic [7:0]       burst_count_ff, burst_count_in;
   logic             ramp_up_ff, ramp_up_in;
   logic             ramp_down_ff, ramp_down_in;
   logic [7:0]       flash_level_ff, flash_level_in;
   logic [7:0]       drive_level_ff, drive_level_in;
   logic [SUB_W-1:0] sub_ms_ff, sub_ms_in;
   logic [31:0]      ms_now_ff, ms_now_in;
   logic [31:0]      ms_mark_ff, ms_mark_in;
   logic [31:0]      us_now_ff, us_now_in;
   logic [31:0]      ramp_mark_ff, ramp_mark_in;

   // Result register
   logic             rsp_valid_ff;
   logic [15:0]      rsp_data_ff;

   logic             req_accept;
   logic             csr_write;
   logic             run_pass;
   phase_type        pass_phase;
   logic [SUB_W:0]   sub_inc;
   logic [31:0]      ms_elapsed;
   logic [31:0]      us_elapsed;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_paddr[4:2])
         REG_ON_MS:          csr_prdata = {16'd0, on_ms_ff};
         REG_OFF_MS:         csr_prdata = {16'd0, off_ms_ff};
         REG_PAUSE_MS:       csr_prdata = {16'd0, pause_ms_ff};
         REG_START_DELAY_MS: csr_prdata = {16'd0, start_delay_ms_ff};
         REG_PULSES:         csr_prdata = {24'd0, pulses_ff};
         REG_REPEATS:        csr_prdata = {24'd0, repeats_ff};
         REG_RAMP_STEP_US:   csr_prdata = {24'd0, ramp_step_ff};
         REG_DIM_LEVEL:      csr_prdata = {24'd0, dim_level_ff};
         default:            csr_prdata = 32'd0;
      endcase
   end

   always_comb begin
      ms_now_in      = ms_now_ff;
      us_now_in      = us_now_ff;
      sub_ms_in      = sub_ms_ff;
      phase_in       = phase_ff;
      ms_mark_in     = ms_mark_ff;
      pulse_count_in = pulse_count_ff;
      burst_count_in = burst_count_ff;
      ramp_up_in     = ramp_up_ff;
      ramp_down_in   = ramp_down_ff;
      flash_level_in = flash_level_ff;
      drive_level_in = drive_level_ff;
      ramp_mark_in   = ramp_mark_ff;
      run_pass       = 1'b0;
      sub_inc        = {1'b0, sub_ms_ff} + 1'b1;

      unique case (req_tuser)
         CMD_TICK: begin
            us_now_in = us_now_ff + 32'd1;
            if (sub_inc >= TICKS_C) begin
               sub_ms_in = '0;
               ms_now_in = ms_now_ff + 32'd1;
            end else begin
               sub_ms_in = sub_inc[SUB_W-1:0];
            end
            run_pass = 1'b1;
         end
         CMD_START: begin
            pulse_count_in = 8'd0;
            burst_count_in = 8'd0;
            ms_mark_in     = ms_now_ff;
            phase_in       = (start_delay_ms_ff == 16'd0) ? PH_PULSE_ON : PH_DELAY;
            run_pass       = 1'b1;
         end
         CMD_FULL: begin
            phase_in       = PH_IDLE;
            drive_level_in = FULL_LEVEL;
         end
         CMD_LEVEL: begin
            phase_in       = PH_IDLE;
            drive_level_in = req_tdata;
         end
      endcase

      pass_phase = phase_in;
      ms_elapsed = ms_now_in - ms_mark_in;
      us_elapsed = us_now_in - ramp_mark_ff;

      if (run_pass) begin
         if (pass_phase == PH_IDLE) begin
            // An idle sequencer only tracks time; the drive level is left alone.
            ms_mark_in = ms_now_in;
         end else begin
            unique case (pass_phase)
               PH_DELAY: begin
                  if (ms_elapsed >= {16'd0, start_delay_ms_ff}) phase_in = PH_PULSE_ON;
               end
               PH_PULSE_ON: begin
                  ramp_up_in     = 1'b1;
                  ramp_down_in   = 1'b0;
                  pulse_count_in = pulse_count_in + 8'd1;
                  ms_mark_in     = ms_now_in;
                  phase_in       = PH_ON;
               end
               PH_ON: begin
                  if (ms_elapsed >= {16'd0, on_ms_ff}) phase_in = PH_PULSE_OFF;
               end
               PH_PULSE_OFF: begin
                  ramp_down_in = 1'b1;
                  ramp_up_in   = 1'b0;
                  ms_mark_in   = ms_now_in;
                  phase_in     = PH_OFF;
               end
               PH_OFF: begin
                  if (ms_elapsed >= {16'd0, off_ms_ff}) phase_in = PH_BURST;
               end
               PH_BURST: begin
                  // A burst always has at least one pulse, even with a zero count.
                  if (pulse_count_in >= pulses_ff) begin
                     pulse_count_in = 8'd0;
                     ms_mark_in     = ms_now_in;
                     burst_count_in = burst_count_in + 8'd1;
                     if (repeats_ff != 8'd0 && burst_count_in >= repeats_ff) begin
                        phase_in = PH_IDLE;
                     end else begin
                        phase_in = PH_PAUSE;
                     end
                  end else begin
                     phase_in = PH_PULSE_ON;
                  end
               end
               PH_PAUSE: begin
                  if (ms_elapsed >= {16'd0, pause_ms_ff}) phase_in = PH_PULSE_ON;
               end
               default: begin
                  phase_in = pass_phase;
               end
            endcase

            if (ramp_step_ff != 8'd0) begin
               if (us_elapsed >= {24'd0, ramp_step_ff}) begin
                  ramp_mark_in = us_now_in;
                  if (ramp_up_in && flash_level_in < FULL_LEVEL) begin
                     flash_level_in = flash_level_in + 8'd1;
                  end
                  if (flash_level_in == FULL_LEVEL || ramp_down_in) ramp_up_in = 1'b0;
                  if (ramp_down_in && flash_level_in > dim_level_ff) begin
                     flash_level_in = flash_level_in - 8'd1;
                  end
                  if (flash_level_in == dim_level_ff) ramp_down_in = 1'b0;
               end
            end else begin
               if (ramp_up_in) begin
                  flash_level_in = FULL_LEVEL;
                  ramp_up_in     = 1'b0;
               end
               if (ramp_down_in) begin
                  flash_level_in = dim_level_ff;
                  ramp_down_in   = 1'b0;
               end
            end
            drive_level_in = flash_level_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_ms_ff          <= 16'd0;
         off_ms_ff         <= 16'd0;
         pause_ms_ff       <= 16'd0;
         start_delay_ms_ff <= 16'd0;
         pulses_ff         <= 8'd0;
         repeats_ff        <= 8'd0;
         ramp_step_ff      <= 8'd0;
         dim_level_ff      <= 8'd0;
         phase_ff          <= PH_IDLE;
         pulse_count_ff    <= 8'd0;
         burst_count_ff    <= 8'd0;
         ramp_up_ff        <= 1'b0;
         ramp_down_ff      <= 1'b0;
         flash_level_ff    <= 8'd0;
         drive_level_ff    <= 8'd0;
         sub_ms_ff         <= '0;
         ms_now_ff         <= 32'd0;
         ms_mark_ff        <= 32'd0;
         us_now_ff         <= 32'd0;
         ramp_mark_ff      <= 32'd0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_paddr[4:2])
               REG_ON_MS:          on_ms_ff          <= csr_pwdata[15:0];
               REG_OFF_MS:         off_ms_ff         <= csr_pwdata[15:0];
               REG_PAUSE_MS:       pause_ms_ff       <= csr_pwdata[15:0];
               REG_START_DELAY_MS: start_delay_ms_ff <= csr_pwdata[15:0];
               REG_PULSES:         pulses_ff         <= csr_pwdata[7:0];
               REG_REPEATS:        repeats_ff        <= csr_pwdata[7:0];
               REG_RAMP_STEP_US:   ramp_step_ff      <= csr_pwdata[7:0];
               REG_DIM_LEVEL:      dim_level_ff      <= csr_pwdata[7:0];
               default: begin
               end
            endcase
         end
         if (req_accept) begin
            phase_ff       <= phase_in;
            pulse_count_ff <= pulse_count_in;
            burst_count_ff <= burst_count_in;
            ramp_up_ff     <= ramp_up_in;
            ramp_down_ff   <= ramp_down_in;
            flash_level_ff <= flash_level_in;
            drive_level_ff <= drive_level_in;
            sub_ms_ff      <= sub_ms_in;
            ms_now_ff      <= ms_now_in;
            ms_mark_ff     <= ms_mark_in;
            us_now_ff      <= us_now_in;
            ramp_mark_ff   <= ramp_mark_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_accept) begin
         rsp_data_ff <= {6'd0, (phase_in == PH_ON), (phase_in == PH_IDLE), drive_level_in};
      end
   end

   a_result_follows_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_tvalid)
      else $error("accepted beat produced no result");

   a_idle_not_on: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[8] && rsp_tdata[9]))
      else $error("result flags idle and on phase together");

   a_force_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_tuser == CMD_FULL || req_tuser == CMD_LEVEL))
      |=> (rsp_tdata[8] && phase_ff == PH_IDLE))
      else $error("force command did not stop the sequencer");

   a_ms_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (ms_now_ff == $past(ms_now_ff) || ms_now_ff == $past(ms_now_ff) + 32'd1))
      else $error("millisecond count moved by more than one");

   a_sub_ms_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, sub_ms_ff} < TICKS_C)
      else $error("sub-millisecond count out of range");

endmodule

`default_nettype wire

// ===== test/tb_led_flash_pattern_sequencer_core.sv =====
`timescale 1ns / 1ps

module tb_led_flash_pattern_sequencer_core;
   import lfps_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;

   typedef enum logic [2:0] {
      PH_IDLE, PH_DELAY, PH_PULSE_ON, PH_ON_WAIT,
      PH_PULSE_OFF, PH_OFF_WAIT, PH_BURST_CHECK, PH_PAUSE
   } flash_phase_type;

   typedef struct packed {
      logic [7:0] brightness;
      logic       done_res;
      logic       on_phase;
   } led_out_type;

   // A directed row carries its own expectation where known is set.
   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  lvl;
      logic        known;
      led_out_type want;
   } stim_row_type;

   typedef struct packed {
      logic [15:0] on_ms;
      logic [15:0] off_ms;
      logic [15:0] pause_ms;
      logic [15:0] start_delay_ms;
      logic [7:0]  pulses;
      logic [7:0]  repeats;
      logic [7:0]  ramp_step_us;
      logic [7:0]  dim_level;
   } flash_cfg_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] level
   logic [1:0]  req_tuser = CMD_TICK; // [1:0] command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // [7:0] brightness, [8] done_res, [9] on_phase
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = 32'h0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   led_flash_pattern_sequencer_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Sequencer shadow state.
   flash_cfg_type   cfg;
   flash_phase_type seq_phase;
   logic [7:0]      pulse_cnt, burst_cnt, flash_lvl, drive_lvl;
   logic            ramping_up, ramping_down;
   logic [31:0]     tick_in_ms, now_ms, mark_ms, now_us, mark_ramp_us;

   stim_row_type    pending_rows_q[$];
   led_out_type     expected_leds_q[$];
   int unsigned     mismatches = 0;
   int unsigned     results_seen = 0;
   int unsigned     cycles = 0;
   logic            req_quiet = 1'b0;
   logic            rsp_quiet = 1'b0;

   function automatic void sequence_pass();
      case (seq_phase)
         PH_IDLE: begin
            mark_ms = now_ms;
            return;
         end
         PH_DELAY:
            if (now_ms - mark_ms >= {16'd0, cfg.start_delay_ms}) seq_phase = PH_PULSE_ON;
         PH_PULSE_ON: begin
            ramping_up   = 1'b1;
            ramping_down = 1'b0;
            pulse_cnt    = pulse_cnt + 8'd1;
            mark_ms      = now_ms;
            seq_phase    = PH_ON_WAIT;
         end
         PH_ON_WAIT:
            if (now_ms - mark_ms >= {16'd0, cfg.on_ms}) seq_phase = PH_PULSE_OFF;
         PH_PULSE_OFF: begin
            ramping_down = 1'b1;
            ramping_up   = 1'b0;
            mark_ms      = now_ms;
            seq_phase    = PH_OFF_WAIT;
         end
         PH_OFF_WAIT:
            if (now_ms - mark_ms >= {16'd0, cfg.off_ms}) seq_phase = PH_BURST_CHECK;
         PH_BURST_CHECK: begin
            // A burst always emits at least one pulse, even with zero configured.
            if (pulse_cnt >= cfg.pulses) begin
               pulse_cnt = 8'd0;
               mark_ms   = now_ms;
               burst_cnt = burst_cnt + 8'd1;
               if (cfg.repeats != 8'd0 && burst_cnt >= cfg.repeats) seq_phase = PH_IDLE;
               else seq_phase = PH_PAUSE;
            end else begin
               seq_phase = PH_PULSE_ON;
            end
         end
         default:
            if (now_ms - mark_ms >= {16'd0, cfg.pause_ms}) seq_phase = PH_PULSE_ON;
      endcase

      if (cfg.ramp_step_us != 8'd0) begin
         if (now_us - mark_ramp_us >= {24'd0, cfg.ramp_step_us}) begin
            mark_ramp_us = now_us;
            if (ramping_up && flash_lvl < FULL_LEVEL) flash_lvl = flash_lvl + 8'd1;
            if (flash_lvl == FULL_LEVEL || ramping_down) ramping_up = 1'b0;
            if (ramping_down && flash_lvl > cfg.dim_level) flash_lvl = flash_lvl - 8'd1;
            if (flash_lvl == cfg.dim_level) ramping_down = 1'b0;
         end
      end else begin
         if (ramping_up) begin
            flash_lvl  = FULL_LEVEL;
            ramping_up = 1'b0;
         end
         if (ramping_down) begin
            flash_lvl    = cfg.dim_level;
            ramping_down = 1'b0;
         end
      end
      drive_lvl = flash_lvl;
   endfunction

   function automatic led_out_type flash_step(input logic [1:0] cmd, input logic [7:0] lvl);
      led_out_type r;
      case (cmd)
         CMD_TICK: begin
            now_us     = now_us + 32'd1;
            tick_in_ms = tick_in_ms + 32'd1;
            if (tick_in_ms >= TICKS_PER_MS_DEFAULT) begin
               tick_in_ms = 32'd0;
               now_ms     = now_ms + 32'd1;
            end
            sequence_pass();
         end
         CMD_START: begin
            pulse_cnt = 8'd0;
            burst_cnt = 8'd0;
            mark_ms   = now_ms;
            seq_phase = (cfg.start_delay_ms == 16'd0) ? PH_PULSE_ON : PH_DELAY;
            sequence_pass();
         end
         CMD_FULL: begin
            seq_phase = PH_IDLE;
            drive_lvl = FULL_LEVEL;
         end
         default: begin
            seq_phase = PH_IDLE;
            drive_lvl = lvl;
         end
      endcase
      r.brightness = drive_lvl;
      r.done_res   = (seq_phase == PH_IDLE);
      r.on_phase   = (seq_phase == PH_ON_WAIT);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      $display("[%0t] result %0d: %s is %0d, expected %0d",
               $time, results_seen, what, got, want);
   endtask

   always @(posedge clock) begin : check_results
      stim_row_type row;
      led_out_type  predicted;
      led_out_type  want;
      if (reset) begin
         cfg          = '0;
         seq_phase    = PH_IDLE;
         pulse_cnt    = 8'd0;
         burst_cnt    = 8'd0;
         flash_lvl    = 8'd0;
         drive_lvl    = 8'd0;
         ramping_up   = 1'b0;
         ramping_down = 1'b0;
         tick_in_ms   = 32'd0;
         now_ms       = 32'd0;
         mark_ms      = 32'd0;
         now_us       = 32'd0;
         mark_ramp_us = 32'd0;
      end else begin
         if (req_tvalid && req_tready) begin
            row = pending_rows_q.pop_front();
            predicted = flash_step(req_tuser, req_tdata);
            expected_leds_q.push_back(row.known ? row.want : predicted);
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_leds_q.size() == 0) begin
               report_mismatch("beat with nothing expected, tdata", 32'(rsp_tdata), 32'd0);
            end else begin
               want = expected_leds_q.pop_front();
               if (rsp_tdata[7:0] !== want.brightness)
                  report_mismatch("brightness", 32'(rsp_tdata[7:0]), 32'(want.brightness));
               if (rsp_tdata[8] !== want.done_res)
                  report_mismatch("done_res", 32'(rsp_tdata[8]), 32'(want.done_res));
               if (rsp_tdata[9] !== want.on_phase)
                  report_mismatch("on_phase", 32'(rsp_tdata[9]), 32'(want.on_phase));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Result side: a fresh stall for every beat, with occasional runs of none.
   initial begin : drain_side
      int stall;
      forever begin
         if ($urandom_range(0, 39) == 0) rsp_quiet = !rsp_quiet;
         stall = rsp_quiet ? 0 : $urandom_range(0, 13);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic send_beat(input stim_row_type row);
      int gap;
      if ($urandom_range(0, 39) == 0) req_quiet = !req_quiet;
      gap = req_quiet ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      pending_rows_q.push_back(row);
      req_tvalid <= 1'b1;
      req_tuser  <= row.cmd;
      req_tdata  <= row.lvl;
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic stim_row_type open_row(input logic [1:0] cmd, input logic [7:0] lvl);
      return {cmd, lvl, 1'b0, 10'h000};
   endfunction

   // Stops the input side and lets every outstanding beat come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_leds_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // psel stays high between back-to-back writes; the caller drops it.
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
   endtask

   // Junk above each register's width must be dropped by the block.
   task automatic apply_setting(input flash_cfg_type s);
      logic [31:0] junk;
      junk = $urandom();
      csr_write(REG_ON_MS,          {junk[31:16], s.on_ms});
      csr_write(REG_OFF_MS,         {junk[15:0],  s.off_ms});
      csr_write(REG_PAUSE_MS,       {junk[23:8],  s.pause_ms});
      csr_write(REG_START_DELAY_MS, {junk[7:0], junk[31:24], s.start_delay_ms});
      csr_write(REG_PULSES,         {junk[31:8],  s.pulses});
      csr_write(REG_REPEATS,        {junk[23:0],  s.repeats});
      csr_write(REG_RAMP_STEP_US,   {junk[27:4],  s.ramp_step_us});
      csr_write(REG_DIM_LEVEL,      {junk[30:7],  s.dim_level});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      cfg = s;
   endtask

   function automatic flash_cfg_type flash_setting(
      input int on_ms, input int off_ms, input int pause_ms, input int delay_ms,
      input int pulses, input int repeats, input int ramp_us, input int dim);
      flash_cfg_type s;
      s.on_ms          = on_ms[15:0];
      s.off_ms         = off_ms[15:0];
      s.pause_ms       = pause_ms[15:0];
      s.start_delay_ms = delay_ms[15:0];
      s.pulses         = pulses[7:0];
      s.repeats        = repeats[7:0];
      s.ramp_step_us   = ramp_us[7:0];
      s.dim_level      = dim[7:0];
      return s;
   endfunction

   // Each setting opens with a start, then mostly ticks; noise_pct of the beats
   // are restarts or forced levels.
   task automatic run_setting(input flash_cfg_type s, input int n_beats, input int noise_pct);
      int r;
      drain_results();
      apply_setting(s);
      send_beat(open_row(CMD_START, 8'($urandom_range(0, 255))));
      for (int i = 0; i < n_beats; i++) begin
         r = $urandom_range(0, 99);
         if (r >= noise_pct) send_beat(open_row(CMD_TICK, 8'($urandom_range(0, 255))));
         else if (r % 4 < 2) send_beat(open_row(CMD_START, 8'($urandom_range(0, 255))));
         else if (r % 4 == 2) send_beat(open_row(CMD_FULL, 8'($urandom_range(0, 255))));
         else send_beat(open_row(CMD_LEVEL, 8'($urandom_range(0, 255))));
      end
   endtask

   stim_row_type directed_rows [0:21] = '{
      {CMD_TICK,  8'h00, 1'b1, 8'h00, 1'b1, 1'b0},
      {CMD_LEVEL, 8'hFF, 1'b1, 8'hFF, 1'b1, 1'b0},
      {CMD_LEVEL, 8'h00, 1'b1, 8'h00, 1'b1, 1'b0},
      {CMD_FULL,  8'h5A, 1'b1, 8'hFF, 1'b1, 1'b0},
      {CMD_LEVEL, 8'hA5, 1'b1, 8'hA5, 1'b1, 1'b0},
      {CMD_TICK,  8'h00, 1'b1, 8'hA5, 1'b1, 1'b0},
      // Reset settings: zero pulses per burst and endless bursts.
      {CMD_START, 8'h3C, 1'b0, 10'h000},
      {CMD_TICK,  8'h00, 1'b0, 10'h000},
      {CMD_TICK,  8'h00, 1'b0, 10'h000},
      {CMD_TICK,  8'h00, 1'b0, 10'h000},
      {CMD_TICK,  8'h00, 1'b0, 10'h000},
      {CMD_TICK,  8'h00, 1'b0, 10'h000},
      {CMD_TICK,  8'h00, 1'b0, 10'h000},
      {CMD_LEVEL, 8'h5A, 1'b1, 8'h5A, 1'b1, 1'b0},
      {CMD_START, 8'h00, 1'b0, 10'h000},
      {CMD_TICK,  8'h00, 1'b0, 10'h000},
      {CMD_FULL,  8'h00, 1'b1, 8'hFF, 1'b1, 1'b0},
      {CMD_TICK,  8'hFF, 1'b1, 8'hFF, 1'b1, 1'b0},
      {CMD_START, 8'hC3, 1'b0, 10'h000},
      {CMD_TICK,  8'h00, 1'b0, 10'h000},
      {CMD_TICK,  8'h00, 1'b0, 10'h000},
      {CMD_TICK,  8'h00, 1'b0, 10'h000}
   };

   initial begin : stimulus
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_beat(directed_rows[i]);

      // Zero pulses per burst with a single burst.
      run_setting(flash_setting(0, 0, 0, 0, 0, 1, 0, 0), 30, 8);
      // Endless bursts long enough for the burst counter to wrap.
      run_setting(flash_setting(0, 0, 0, 0, 0, 0, 0, 77), 1560, 0);
      // Millisecond on time and pause, ramped towards a dim level of full.
      run_setting(flash_setting(1, 0, 1, 0, 1, 0, 3, 255), 60, 0);
      run_setting(flash_setting(0, 0, 0, 1, 3, 2, 1, 40), 50, 5);
      run_setting(flash_setting(65535, 0, 65535, 0, 255, 255, 255, 0), 40, 10);
      run_setting(flash_setting(0, 65535, 0, 65535, 1, 1, 0, 128), 40, 10);
      run_setting(flash_setting(0, 0, 0, 0, 255, 0, 2, 10), 40, 3);
      for (int k = 0; k < 4; k++)
         run_setting(flash_setting($urandom_range(0, 1), $urandom_range(0, 1),
                                   $urandom_range(0, 1), $urandom_range(0, 1),
                                   $urandom_range(0, 4), $urandom_range(0, 3),
                                   $urandom_range(0, 5), $urandom_range(0, 255)),
                     20, 10);

      drain_results();
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
